### rtl/fca_pkg.sv
// shared types and codes of the cluster allocation table
package fca_pkg;

	localparam int ENTRY_W = 12;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_ALLOC = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SMALL_LIM = 2'd1;
	localparam logic [1:0] ST_TOO_FEW   = 2'd2;
	localparam logic [1:0] ST_ZERO_REQ  = 2'd3;

	localparam logic [ENTRY_W-1:0] ENTRY_FREE   = 12'h000;
	localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 12'hFFF;
	localparam logic [ENTRY_W-1:0] LIMIT_CAP    = 12'd4085;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [ENTRY_W-1:0] cluster_index;
		logic [ENTRY_W-1:0] entry_value;
		logic [ENTRY_W-1:0] request_count;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ENTRY_W-1:0] found_count;
		logic [ENTRY_W-1:0] chain_head;
		logic [ENTRY_W-1:0] read_value;
	} res_t;

endpackage

### rtl/fca_ram.sv
// generic simple dual port ram with registered read
module fca_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/fca_engine.sv
// request sequencer: table clear, read, write and two-pass chain allocation
module fca_engine
	import fca_pkg::*;
#(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  req_t                             req,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] lim,
	input  logic                             out_free,
	output logic                             res_valid,
	output res_t                             res
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [12:0]   DEPTH13   = 13'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_RDWT  = 3'd3;
	localparam logic [2:0] S_COUNT = 3'd4;
	localparam logic [2:0] S_LINK  = 3'd5;
	localparam logic [2:0] S_TAIL  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]         state_q;
	logic [AW-1:0]      clr_q;
	req_t               req_q;
	logic [CW-1:0]      scan_q;
	logic               pend_s1;
	logic [AW-1:0]      pend_addr_s1;
	logic [ENTRY_W-1:0] cnt_q;
	logic [AW-1:0]      prev_q;
	logic [ENTRY_W-1:0] first_q;
	res_t               res_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] rd_data;

	logic idx_ok;
	logic hit;
	logic scan_more;

	fca_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// clusters 0 and 1 and anything past the table are reserved
	assign idx_ok = (req_q.cluster_index >= 12'd2) &&
		({1'b0, req_q.cluster_index} < DEPTH13);
	assign hit = pend_s1 && (rd_data == ENTRY_FREE) && (cnt_q < req_q.request_count);
	assign scan_more = (scan_q < lim) && (cnt_q < req_q.request_count);

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE) && out_free;
	assign res = res_q;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = prev_q;
		wr_data = 12'(pend_addr_s1);
		rd_en = 1'b0;
		rd_addr = scan_q[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
				wr_data = ENTRY_FREE;
			end
			S_EXEC: begin
				wr_addr = req_q.cluster_index[AW-1:0];
				wr_data = req_q.entry_value;
				rd_addr = req_q.cluster_index[AW-1:0];
				wr_en = (req_q.opcode == OP_WRITE) && idx_ok;
				rd_en = (req_q.opcode == OP_READ) && idx_ok;
			end
			S_COUNT: begin
				rd_en = scan_more;
			end
			S_LINK: begin
				rd_en = scan_more;
				// link the previous free cluster to this one
				wr_en = hit && (first_q != ENTRY_FREE);
			end
			S_TAIL: begin
				wr_en = 1'b1;
				wr_data = END_OF_CHAIN;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					if (req_q.opcode == OP_READ) begin
						state_q <= S_RDWT;
					end else if (req_q.opcode == OP_ALLOC) begin
						if (lim >= CW'(3) && req_q.request_count != '0) begin
							state_q <= S_COUNT;
						end
					end
				end
				S_RDWT: begin
					state_q <= S_DONE;
				end
				S_COUNT: begin
					pend_s1 <= rd_en;
					if (cnt_q == req_q.request_count) begin
						pend_s1 <= 1'b0;
						state_q <= S_LINK;
					end else if (!pend_s1 && !(scan_q < lim)) begin
						state_q <= S_DONE;
					end
				end
				S_LINK: begin
					pend_s1 <= rd_en;
					if (cnt_q == req_q.request_count) begin
						pend_s1 <= 1'b0;
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_s1 <= scan_q[AW-1:0];
		if (rd_en) begin
			scan_q <= scan_q + 1'b1;
		end
		case (state_q)
			S_IDLE: begin
				req_q <= req;
			end
			S_EXEC: begin
				res_q <= '0;
				scan_q <= CW'(2);
				cnt_q <= '0;
				first_q <= ENTRY_FREE;
				prev_q <= '0;
				if (req_q.opcode == OP_ALLOC) begin
					if (lim < CW'(3)) begin
						res_q.status <= ST_SMALL_LIM;
					end else if (req_q.request_count == '0) begin
						res_q.status <= ST_ZERO_REQ;
					end
				end
			end
			S_RDWT: begin
				res_q.read_value <= idx_ok ? rd_data : END_OF_CHAIN;
			end
			S_COUNT: begin
				if (hit) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (cnt_q == req_q.request_count) begin
					// second pass starts over from cluster 2
					scan_q <= CW'(2);
					cnt_q <= '0;
				end else if (!pend_s1 && !(scan_q < lim)) begin
					res_q.status <= ST_TOO_FEW;
					res_q.found_count <= cnt_q;
				end
			end
			S_LINK: begin
				if (hit) begin
					cnt_q <= cnt_q + 1'b1;
					prev_q <= pend_addr_s1;
					if (first_q == ENTRY_FREE) begin
						first_q <= 12'(pend_addr_s1);
					end
				end
			end
			S_TAIL: begin
				res_q.status <= ST_OK;
				res_q.found_count <= cnt_q;
				res_q.chain_head <= first_q;
			end
			default: begin
			end
		endcase
	end

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("table write and read hit the same cluster");

	a_res_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result issued while output register is full");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COUNT || state_q == S_LINK) |-> (cnt_q <= req_q.request_count))
		else $error("free count passed the request");

	a_link_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK) |-> (scan_q <= lim))
		else $error("link pass ran past the cluster limit");

	a_tail_after_link: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAIL) |-> (first_q >= 12'd2))
		else $error("end of chain written with no chain head");

endmodule

### rtl/fat12_cluster_chain_allocator_unit.sv
// top level of the cluster allocation table: config register, engine, output register
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser opcode, tdata index/value/count
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata read/head/found/status
// cfg       in   cfg_valid/cfg_ready           cluster_limit
//
// after reset the table is cleared one entry a cycle; no word is taken until it is clear
// write, the unused opcode and a rejected allocate go straight to the result; read first waits for the table read
// allocate: one table read per cycle in each of the counting and linking scans, which
// run from cluster 2 up to the limit
// the output register frees the engine to take the next word while a result waits

module fat12_cluster_chain_allocator_unit
	import fca_pkg::*;
#(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // cluster_index, entry_value, request_count, zero pad
	input  logic [1:0]  s_axis_tuser,   // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // read_value, chain_head, found_count, status, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data        // cluster_limit
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [12:0] DEPTH13 = 13'(TABLE_DEPTH);

	logic [ENTRY_W-1:0] limit_q;
	logic [ENTRY_W-1:0] lim_cap;
	logic [12:0]        lim_full;
	logic [CW-1:0]      lim;
	req_t               req;
	res_t               res;
	logic               res_valid;
	logic               out_free;
	logic               m_valid_q;
	res_t               m_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_CAP;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// saturate to the fat12 cap, then to the table size
	assign lim_cap = (limit_q > LIMIT_CAP) ? LIMIT_CAP : limit_q;
	assign lim_full = ({1'b0, lim_cap} > DEPTH13) ? DEPTH13 : {1'b0, lim_cap};
	assign lim = lim_full[CW-1:0];

	assign req.opcode = s_axis_tuser;
	assign req.cluster_index = s_axis_tdata[11:0];
	assign req.entry_value = s_axis_tdata[23:12];
	assign req.request_count = s_axis_tdata[35:24];

	assign out_free = !m_valid_q || m_axis_tready;

	fca_engine #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.lim       (lim),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_data_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {2'b00, m_data_q};

endmodule

### tb/sv/fat12_alloc_checker.sv
`timescale 1ns / 1ps
// checker: mirrors the cluster table, predicts each result word and compares it
module fat12_alloc_checker
	import fca_pkg::*;
#(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [11:0] cfg_data,
	output int          errors,
	output int          pending
);

	logic [ENTRY_W-1:0] fat_copy [TABLE_DEPTH];
	logic [ENTRY_W-1:0] limit_copy;
	res_t               expected_outcomes [$];
	int                 error_tally;

	function automatic int unsigned scan_bound();
		int unsigned bound;
		bound = limit_copy;
		if (bound > LIMIT_CAP) bound = LIMIT_CAP;
		if (bound > TABLE_DEPTH) bound = TABLE_DEPTH;
		return bound;
	endfunction

	// clusters 0 and 1 are reserved and so is anything past the table
	function automatic logic [ENTRY_W-1:0] entry_read(int unsigned idx);
		if (idx < 2 || idx >= TABLE_DEPTH) return END_OF_CHAIN;
		return fat_copy[idx];
	endfunction

	function automatic void entry_store(int unsigned idx, logic [ENTRY_W-1:0] val);
		if (idx >= 2 && idx < TABLE_DEPTH) fat_copy[idx] = val;
	endfunction

	function automatic res_t allocate_chain(logic [ENTRY_W-1:0] count);
		res_t        outcome;
		int unsigned bound;
		int unsigned found;
		int unsigned prev;
		int unsigned linked;
		outcome = '0;
		bound = scan_bound();
		if (bound < 3) begin
			outcome.status = ST_SMALL_LIM;
		end else if (count == 0) begin
			outcome.status = ST_ZERO_REQ;
		end else begin
			found = 0;
			for (int unsigned c = 2; c < bound && found < count; c++) begin
				if (fat_copy[c] == ENTRY_FREE) found++;
			end
			outcome.found_count = ENTRY_W'(found);
			if (found < count) begin
				outcome.status = ST_TOO_FEW;
			end else begin
				prev = 0;
				linked = 0;
				for (int unsigned c = 2; c < bound && linked < count; c++) begin
					if (fat_copy[c] == ENTRY_FREE) begin
						if (prev == 0) outcome.chain_head = ENTRY_W'(c);
						else entry_store(prev, ENTRY_W'(c));
						prev = c;
						linked++;
					end
				end
				entry_store(prev, END_OF_CHAIN);
			end
		end
		return outcome;
	endfunction

	function automatic res_t predict_outcome(req_t r);
		res_t outcome;
		outcome = '0;
		case (r.opcode)
			OP_WRITE: entry_store(r.cluster_index, r.entry_value);
			OP_READ:  outcome.read_value = entry_read(r.cluster_index);
			OP_ALLOC: outcome = allocate_chain(r.request_count);
			default:  outcome = '0;
		endcase
		return outcome;
	endfunction

	function automatic void check_field(string name, logic [ENTRY_W-1:0] want,
			logic [ENTRY_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_tally++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		req_t taken;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) fat_copy[i] = ENTRY_FREE;
			limit_copy = LIMIT_CAP;
			expected_outcomes.delete();
			error_tally = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) limit_copy = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_outcomes.size() == 0) begin
					$display("%0t: result word with none expected, expected none, actual %h",
						$time, m_axis_tdata);
					error_tally++;
				end else begin
					want = expected_outcomes.pop_front();
					check_field("read_value", want.read_value, m_axis_tdata[11:0]);
					check_field("chain_head", want.chain_head, m_axis_tdata[23:12]);
					check_field("found_count", want.found_count, m_axis_tdata[35:24]);
					check_field("status", ENTRY_W'(want.status), ENTRY_W'(m_axis_tdata[37:36]));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				taken = '{opcode: s_axis_tuser, cluster_index: s_axis_tdata[11:0],
					entry_value: s_axis_tdata[23:12], request_count: s_axis_tdata[35:24]};
				expected_outcomes.push_back(predict_outcome(taken));
			end
			errors <= error_tally;
			pending <= expected_outcomes.size();
		end
	end

endmodule

### tb/sv/tb_fat12_cluster_chain_allocator_unit.sv
`timescale 1ns / 1ps
// testbench top: request stimulus, limit changes, idling and the verdict
module tb_fat12_cluster_chain_allocator_unit
	import fca_pkg::*;
();

	localparam int         TABLE_DEPTH      = 4096;
	localparam logic [1:0] OP_UNUSED        = 2'd3;
	localparam int         CYCLE_LIMIT      = 6_000_000;
	localparam int         RANDOM_PER_PHASE = 11;
	localparam int         PHASES           = 7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [11:0] cfg_data;

	int          errors;
	int          pending;
	int          cycles = 0;
	bit          steady = 1'b0;
	logic [11:0] limit_now = LIMIT_CAP;
	logic [11:0] phase_limits [PHASES] = '{12'd12, 12'd40, LIMIT_CAP, 12'd100, 12'd3,
		LIMIT_CAP, 12'd25};

	always #1 clk = ~clk;

	fat12_cluster_chain_allocator_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	fat12_alloc_checker #(.TABLE_DEPTH(TABLE_DEPTH)) chain_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 17);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[fat12_cluster_chain_allocator_unit] ERROR");
			$finish;
		end
	end

	// valid stays high from one word to the next unless an idle cycle falls between
	task automatic send_request(logic [1:0] op, logic [11:0] idx, logic [11:0] val,
			logic [11:0] cnt);
		while (!steady && $urandom_range(99) < 17) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'b0, cnt, val, idx};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_limit(logic [11:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = value;
	endtask

	// indices mostly near the active limit, values often free or end of chain, so chains get read back and freed
	task automatic random_request();
		logic [1:0]  op;
		logic [11:0] idx;
		logic [11:0] val;
		logic [11:0] cnt;
		int unsigned pick;
		int unsigned span;
		pick = $urandom_range(99);
		op = pick < 30 ? OP_WRITE : pick < 55 ? OP_READ : pick < 93 ? OP_ALLOC : OP_UNUSED;
		idx = 12'($urandom);
		val = 12'($urandom);
		cnt = 12'($urandom);
		span = limit_now + 2;
		if ($urandom_range(99) < 75) idx = 12'($urandom_range(span));
		pick = $urandom_range(99);
		if (pick < 45) val = ENTRY_FREE;
		else if (pick < 60) val = END_OF_CHAIN;
		else if (pick < 80) val = 12'($urandom_range(span));
		pick = $urandom_range(99);
		if (pick < 77) cnt = 12'($urandom_range(6, 1));
		else if (pick < 87) cnt = 12'd0;
		send_request(op, idx, val, cnt);
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_WRITE;
		m_axis_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reserved clusters, table ends and the allocate outcomes at the reset limit
		send_request(OP_READ, 12'd0, 12'd0, 12'd0);
		send_request(OP_WRITE, 12'd0, 12'h123, 12'd0);
		send_request(OP_WRITE, 12'd1, 12'hFFF, 12'd0);
		send_request(OP_READ, 12'd1, 12'd0, 12'd0);
		send_request(OP_READ, 12'd4095, 12'd0, 12'd0);
		send_request(OP_WRITE, 12'd4095, 12'hFFF, 12'd0);
		send_request(OP_READ, 12'd4095, 12'd0, 12'd0);
		send_request(OP_WRITE, 12'd2, 12'hFFF, 12'd0);
		send_request(OP_ALLOC, 12'd0, 12'd0, 12'd0);
		send_request(OP_ALLOC, 12'd0, 12'd0, 12'd3);
		send_request(OP_READ, 12'd3, 12'd0, 12'd0);
		send_request(OP_READ, 12'd5, 12'd0, 12'd0);
		send_request(OP_WRITE, 12'd2, 12'd0, 12'd0);
		send_request(OP_ALLOC, 12'd0, 12'd0, 12'd1);
		send_request(OP_ALLOC, 12'd0, 12'd0, 12'hFFF);
		send_request(OP_UNUSED, 12'hFFF, 12'hFFF, 12'hFFF);

		// limits too small to allocate, then the smallest usable one
		set_limit(12'd0);
		send_request(OP_ALLOC, 12'd0, 12'd0, 12'd0);
		set_limit(12'd1);
		send_request(OP_ALLOC, 12'd0, 12'd0, 12'd5);
		set_limit(12'd2);
		send_request(OP_ALLOC, 12'd0, 12'd0, 12'd1);
		set_limit(12'd3);
		send_request(OP_ALLOC, 12'd0, 12'd0, 12'd1);
		send_request(OP_WRITE, 12'd2, 12'd0, 12'd0);
		send_request(OP_ALLOC, 12'd0, 12'd0, 12'd1);
		send_request(OP_ALLOC, 12'd0, 12'd0, 12'd2);

		for (int p = 0; p < PHASES; p++) begin
			set_limit(phase_limits[p]);
			steady = (p == 3);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n == RANDOM_PER_PHASE / 2 && p == 1) drain_results();
				random_request();
			end
		end
		steady = 1'b0;

		drain_results();
		repeat (16) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[fat12_cluster_chain_allocator_unit] OK");
		end else begin
			$display("[fat12_cluster_chain_allocator_unit] ERROR");
		end
		$finish;
	end

endmodule
